FILE: src/tqls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqls_pkg
// Shared constants, command codes and helpers of the tabular Q-learning unit.
// ----------------------------------------------------------------------------
package tqls_pkg;

    // default table geometry
    localparam int STATE_COUNT_DEF  = 4096;
    localparam int ACTION_COUNT_DEF = 7;

    // fixed field widths
    localparam int STATE_W  = 12;
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int FRAC_W   = 16;

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_MARK  = 2'd1;
    localparam logic [1:0] CMD_LEARN = 2'd2;
    localparam logic [1:0] CMD_EVAL  = 2'd3;

    // register indexes on the config port
    localparam logic [1:0] REG_LEARN_RATE = 2'd0;
    localparam logic [1:0] REG_DISCOUNT   = 2'd1;
    localparam logic [1:0] REG_EXPLORE    = 2'd2;
    localparam logic [1:0] REG_SLIP       = 2'd3;

    // register reset values
    localparam logic [15:0] LEARN_RATE_RST = 16'd13107;
    localparam logic [15:0] DISCOUNT_RST   = 16'd39322;
    localparam logic [15:0] EXPLORE_RST    = 16'd6554;
    localparam logic [15:0] SLIP_RST       = 16'd6554;

    // clamp a 34-bit signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: src/tabular_q_learning_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabular_q_learning_step_unit
// Tabular Q-learning engine: entry load, goal mark, learn and evaluate steps.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; its one result
// shows on the result ports for a single cycle with done high, and the
// receiver has to take it then, as there is no way to hold it off. A new
// command may start in the cycle done is high. All work runs through one
// small sequencer around single-port table memories (the goal marks have a
// separate read address), one 16-step bit-serial remainder unit and one
// registered multiplier. Each step has n available actions (ACTION_COUNT or
// one less); its max scan reads one Q-table entry per cycle and runs once
// for an evaluate step and twice for a learn step. An explore or a slip goes
// through the remainder unit. With STATE_COUNT below 4096 every state number
// first goes through the remainder unit too (twice for a load). After reset,
// a pass clears the goal marks one state per cycle, and busy stays high until
// it ends; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module tabular_q_learning_step_unit #(
    parameter int STATE_COUNT  = tqls_pkg::STATE_COUNT_DEF,
    parameter int ACTION_COUNT = tqls_pkg::ACTION_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    // command channel
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          cmd,
    input  logic [11:0]         state_index,
    input  logic [2:0]          action_index,
    input  logic signed [31:0]  entry_reward,
    input  logic [11:0]         entry_target,
    input  logic                has_seven_actions,
    input  logic [15:0]         explore_draw,
    input  logic [15:0]         explore_action_draw,
    input  logic [15:0]         slip_draw,
    input  logic [15:0]         slip_action_draw,

    // result channel
    output logic                done,
    output logic [2:0]          chosen_action,
    output logic [2:0]          taken_action,
    output logic [11:0]         reached_state,
    output logic signed [31:0]  step_reward,
    output logic signed [31:0]  updated_q,
    output logic                at_goal,

    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SW          = $clog2(STATE_COUNT);
    localparam int AW          = $clog2(ACTION_COUNT);
    localparam int AW1         = $clog2(ACTION_COUNT + 1);
    localparam int ENTRY_COUNT = STATE_COUNT * ACTION_COUNT;
    localparam int EAW         = $clog2(ENTRY_COUNT);
    localparam int DW          = 17;
    localparam bit NEED_MOD    = (STATE_COUNT < 4096);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MOD, S_S_RED, S_T_RED, S_LOAD, S_MARK,
        S_RD_MARK, S_SETN, S_SCAN, S_CHOOSE, S_EX_DONE, S_SLIP, S_SL_DONE,
        S_RD_ENT, S_GOT_ENT, S_MUL1, S_MUL1W, S_ADD1, S_SUB1, S_MUL2W,
        S_ADD2, S_RD_GOAL, S_OUT
    } state_t;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [15:0] learn_rate_reg;
    logic [15:0] discount_reg;
    logic [15:0] explore_thr_reg;
    logic [15:0] slip_thr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register write on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg  <= tqls_pkg::LEARN_RATE_RST;
            discount_reg    <= tqls_pkg::DISCOUNT_RST;
            explore_thr_reg <= tqls_pkg::EXPLORE_RST;
            slip_thr_reg    <= tqls_pkg::SLIP_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                tqls_pkg::REG_LEARN_RATE: learn_rate_reg  <= pwdata[15:0];
                tqls_pkg::REG_DISCOUNT:   discount_reg    <= pwdata[15:0];
                tqls_pkg::REG_EXPLORE:    explore_thr_reg <= pwdata[15:0];
                tqls_pkg::REG_SLIP:       slip_thr_reg    <= pwdata[15:0];
                default:                  learn_rate_reg  <= learn_rate_reg;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        case (paddr[3:2])
            tqls_pkg::REG_LEARN_RATE: prdata = {16'd0, learn_rate_reg};
            tqls_pkg::REG_DISCOUNT:   prdata = {16'd0, discount_reg};
            tqls_pkg::REG_EXPLORE:    prdata = {16'd0, explore_thr_reg};
            tqls_pkg::REG_SLIP:       prdata = {16'd0, slip_thr_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer registers
    // ------------------------------------------------------------------
    state_t             state_reg;
    state_t             mod_ret_reg;
    logic [1:0]         cmd_reg;
    logic [11:0]        tgt_in_reg;
    logic [2:0]         act_reg;
    logic signed [31:0] rew_in_reg;
    logic               seven_reg;
    logic [15:0]        ex_draw_reg;
    logic [15:0]        ex_act_reg;
    logic [15:0]        sl_draw_reg;
    logic [15:0]        sl_act_reg;

    logic [SW-1:0]      s_reg;
    logic [SW-1:0]      tgt_reg;
    logic [SW-1:0]      next_reg;
    logic [SW-1:0]      clr_cnt_reg;
    logic               scan_second_reg;
    logic [AW1-1:0]     n_reg;
    logic [AW1-1:0]     issue_idx_reg;
    logic [AW1-1:0]     data_idx_reg;
    logic               dvld_reg;
    logic signed [31:0] best_q_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [AW-1:0]      chosen_reg;
    logic [AW-1:0]      taken_reg;
    logic signed [31:0] r_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] target_reg;
    logic signed [31:0] newq_reg;

    // remainder unit
    logic [15:0]        mod_dvd_reg;
    logic [DW-1:0]      mod_dsr_reg;
    logic [DW-1:0]      mod_rem_reg;
    logic [3:0]         mod_cnt_reg;
    logic [DW-1:0]      mod_trial;
    logic [DW-1:0]      mod_rem_next;

    // multiplier
    logic signed [32:0] mul_a_reg;
    logic signed [16:0] mul_b_reg;
    logic signed [49:0] prod_reg;
    logic signed [49:0] prod_rnd;
    logic signed [33:0] scaled;
    logic signed [31:0] add_base;
    logic signed [33:0] add_sum;
    logic signed [31:0] add_sat;

    // result registers
    logic               done_reg;
    logic [2:0]         chosen_out_reg;
    logic [2:0]         taken_out_reg;
    logic [11:0]        reached_out_reg;
    logic signed [31:0] reward_out_reg;
    logic signed [31:0] newq_out_reg;
    logic               goal_out_reg;

    // memory read data
    logic signed [31:0] q_rd_reg;
    logic signed [31:0] rew_rd_reg;
    logic [SW-1:0]      succ_rd_reg;
    logic               seven_rd_reg;
    logic               goal_rd_reg;

    // memory controls
    logic [EAW-1:0]     s_row;
    logic [EAW-1:0]     next_row;
    logic [EAW-1:0]     scan_base;
    logic [EAW-1:0]     q_addr;
    logic               q_we;
    logic signed [31:0] q_wdata;
    logic [EAW-1:0]     ent_addr;
    logic               ent_we;
    logic [SW-1:0]      seven_addr;
    logic               seven_we;
    logic [SW-1:0]      goal_waddr;
    logic               goal_we;
    logic               goal_wdata;
    logic               load_ok;
    logic               scan_last;

    // ------------------------------------------------------------------
    // bit-serial remainder step
    // ------------------------------------------------------------------
    assign mod_trial    = {mod_rem_reg[DW-2:0], mod_dvd_reg[15]};
    assign mod_rem_next = (mod_trial >= mod_dsr_reg) ? mod_trial - mod_dsr_reg : mod_trial;

    // ------------------------------------------------------------------
    // shared multiply, rounding and saturating add
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    assign prod_rnd = prod_reg + 50'sd32768;
    assign scaled   = prod_rnd[49:16];
    assign add_base = (state_reg == S_ADD2) ? q_reg : r_reg;
    assign add_sum  = {{2{add_base[31]}}, add_base} + scaled;
    assign add_sat  = tqls_pkg::sat32(add_sum);

    // ------------------------------------------------------------------
    // address generation and write strobes
    // ------------------------------------------------------------------
    assign s_row     = EAW'(s_reg) * EAW'(ACTION_COUNT);
    assign next_row  = EAW'(next_reg) * EAW'(ACTION_COUNT);
    assign scan_base = scan_second_reg ? next_row : s_row;
    assign load_ok   = ({29'd0, act_reg} < 32'(ACTION_COUNT));
    assign scan_last = dvld_reg && (data_idx_reg == n_reg - AW1'(1));

    always_comb
    begin
        q_addr      = scan_base + EAW'(issue_idx_reg);
        q_we        = 1'b0;
        q_wdata     = 32'sd0;
        ent_addr    = s_row + EAW'(taken_reg);
        ent_we      = 1'b0;
        seven_addr  = scan_second_reg ? next_reg : s_reg;
        seven_we    = 1'b0;
        goal_waddr  = s_reg;
        goal_we     = 1'b0;
        goal_wdata  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                goal_waddr = clr_cnt_reg;
                goal_we    = 1'b1;
            end
            S_LOAD:
            begin
                q_addr     = s_row + EAW'(act_reg);
                ent_addr   = s_row + EAW'(act_reg);
                seven_addr = s_reg;
                q_we       = load_ok;
                ent_we     = load_ok;
                seven_we   = load_ok;
            end
            S_MARK:
            begin
                goal_we    = 1'b1;
                goal_wdata = 1'b1;
            end
            S_RD_ENT:
            begin
                q_addr = s_row + EAW'(chosen_reg);
            end
            S_ADD2:
            begin
                q_addr  = s_row + EAW'(chosen_reg);
                q_we    = 1'b1;
                q_wdata = add_sat;
            end
            default:
            begin
                q_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // table memories
    // ------------------------------------------------------------------
    logic signed [31:0] q_mem     [ENTRY_COUNT];
    logic signed [31:0] rew_mem   [ENTRY_COUNT];
    logic [SW-1:0]      succ_mem  [ENTRY_COUNT];
    logic               seven_mem [STATE_COUNT];
    logic               goal_mem  [STATE_COUNT];

    // q table
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_addr] <= q_wdata;
        q_rd_reg <= q_mem[q_addr];
    end

    // reward and successor tables
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            rew_mem[ent_addr]  <= rew_in_reg;
            succ_mem[ent_addr] <= tgt_reg;
        end
        rew_rd_reg  <= rew_mem[ent_addr];
        succ_rd_reg <= succ_mem[ent_addr];
    end

    // seventh-action marks
    always_ff @(posedge clk)
    begin
        if (seven_we)
            seven_mem[seven_addr] <= seven_reg;
        seven_rd_reg <= seven_mem[seven_addr];
    end

    // goal marks
    always_ff @(posedge clk)
    begin
        if (goal_we)
            goal_mem[goal_waddr] <= goal_wdata;
        goal_rd_reg <= goal_mem[next_reg];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    function automatic state_t dispatch(input logic [1:0] c);
        case (c)
            tqls_pkg::CMD_LOAD: return S_LOAD;
            tqls_pkg::CMD_MARK: return S_MARK;
            default:            return S_RD_MARK;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            mod_ret_reg     <= S_IDLE;
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            cmd_reg         <= tqls_pkg::CMD_LOAD;
            tgt_in_reg      <= '0;
            act_reg         <= '0;
            rew_in_reg      <= '0;
            seven_reg       <= 1'b0;
            ex_draw_reg     <= '0;
            ex_act_reg      <= '0;
            sl_draw_reg     <= '0;
            sl_act_reg      <= '0;
            s_reg           <= '0;
            tgt_reg         <= '0;
            next_reg        <= '0;
            scan_second_reg <= 1'b0;
            n_reg           <= '0;
            issue_idx_reg   <= '0;
            data_idx_reg    <= '0;
            dvld_reg        <= 1'b0;
            best_q_reg      <= '0;
            best_idx_reg    <= '0;
            chosen_reg      <= '0;
            taken_reg       <= '0;
            r_reg           <= '0;
            q_reg           <= '0;
            target_reg      <= '0;
            newq_reg        <= '0;
            mod_dvd_reg     <= '0;
            mod_dsr_reg     <= '0;
            mod_rem_reg     <= '0;
            mod_cnt_reg     <= '0;
            mul_a_reg       <= '0;
            mul_b_reg       <= '0;
            chosen_out_reg  <= '0;
            taken_out_reg   <= '0;
            reached_out_reg <= '0;
            reward_out_reg  <= '0;
            newq_out_reg    <= '0;
            goal_out_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                // goal-mark clearing pass after reset
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SW'(1);
                    if (clr_cnt_reg == SW'(STATE_COUNT - 1))
                        state_reg <= S_IDLE;
                end

                // take a command beat
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg         <= cmd;
                        tgt_in_reg      <= entry_target;
                        act_reg         <= action_index;
                        rew_in_reg      <= entry_reward;
                        seven_reg       <= has_seven_actions;
                        ex_draw_reg     <= explore_draw;
                        ex_act_reg      <= explore_action_draw;
                        sl_draw_reg     <= slip_draw;
                        sl_act_reg      <= slip_action_draw;
                        scan_second_reg <= 1'b0;
                        if (NEED_MOD)
                        begin
                            mod_dvd_reg <= {4'd0, state_index};
                            mod_dsr_reg <= DW'(STATE_COUNT);
                            mod_rem_reg <= '0;
                            mod_cnt_reg <= '0;
                            mod_ret_reg <= S_S_RED;
                            state_reg   <= S_MOD;
                        end
                        else
                        begin
                            s_reg     <= SW'(state_index);
                            tgt_reg   <= SW'(entry_target);
                            state_reg <= dispatch(cmd);
                        end
                    end
                end

                // one remainder bit per cycle
                S_MOD:
                begin
                    mod_rem_reg <= mod_rem_next;
                    mod_dvd_reg <= {mod_dvd_reg[14:0], 1'b0};
                    mod_cnt_reg <= mod_cnt_reg + 4'd1;
                    if (mod_cnt_reg == 4'd15)
                        state_reg <= mod_ret_reg;
                end

                // reduced state number ready
                S_S_RED:
                begin
                    s_reg <= SW'(mod_rem_reg);
                    if (cmd_reg == tqls_pkg::CMD_LOAD)
                    begin
                        mod_dvd_reg <= {4'd0, tgt_in_reg};
                        mod_rem_reg <= '0;
                        mod_cnt_reg <= '0;
                        mod_ret_reg <= S_T_RED;
                        state_reg   <= S_MOD;
                    end
                    else
                    begin
                        state_reg <= dispatch(cmd_reg);
                    end
                end

                // reduced target state ready
                S_T_RED:
                begin
                    tgt_reg   <= SW'(mod_rem_reg);
                    state_reg <= S_LOAD;
                end

                // table writes happen in the memory blocks
                S_LOAD, S_MARK:
                begin
                    state_reg <= S_OUT;
                end

                // mark read issued for the row being scanned
                S_RD_MARK:
                begin
                    state_reg <= S_SETN;
                end

                // available action count of the row
                S_SETN:
                begin
                    n_reg         <= seven_rd_reg ? AW1'(ACTION_COUNT) :
                                                    AW1'(ACTION_COUNT - 1);
                    issue_idx_reg <= '0;
                    dvld_reg      <= 1'b0;
                    state_reg     <= S_SCAN;
                end

                // pipelined max scan, first maximum kept
                S_SCAN:
                begin
                    if (issue_idx_reg < n_reg)
                    begin
                        issue_idx_reg <= issue_idx_reg + AW1'(1);
                        data_idx_reg  <= issue_idx_reg;
                        dvld_reg      <= 1'b1;
                    end
                    else
                    begin
                        dvld_reg <= 1'b0;
                    end
                    if (dvld_reg && (data_idx_reg == '0 || q_rd_reg > best_q_reg))
                    begin
                        best_q_reg   <= q_rd_reg;
                        best_idx_reg <= AW'(data_idx_reg);
                    end
                    if (scan_last)
                        state_reg <= scan_second_reg ? S_MUL1 : S_CHOOSE;
                end

                // epsilon-greedy choice
                S_CHOOSE:
                begin
                    if (cmd_reg == tqls_pkg::CMD_LEARN && ex_draw_reg <= explore_thr_reg)
                    begin
                        mod_dvd_reg <= ex_act_reg;
                        mod_dsr_reg <= DW'(n_reg);
                        mod_rem_reg <= '0;
                        mod_cnt_reg <= '0;
                        mod_ret_reg <= S_EX_DONE;
                        state_reg   <= S_MOD;
                    end
                    else
                    begin
                        chosen_reg <= best_idx_reg;
                        state_reg  <= S_SLIP;
                    end
                end

                S_EX_DONE:
                begin
                    chosen_reg <= AW'(mod_rem_reg);
                    state_reg  <= S_SLIP;
                end

                // random slip
                S_SLIP:
                begin
                    if (sl_draw_reg <= slip_thr_reg)
                    begin
                        mod_dvd_reg <= sl_act_reg;
                        mod_dsr_reg <= DW'(n_reg);
                        mod_rem_reg <= '0;
                        mod_cnt_reg <= '0;
                        mod_ret_reg <= S_SL_DONE;
                        state_reg   <= S_MOD;
                    end
                    else
                    begin
                        taken_reg <= chosen_reg;
                        state_reg <= S_RD_ENT;
                    end
                end

                S_SL_DONE:
                begin
                    taken_reg <= AW'(mod_rem_reg);
                    state_reg <= S_RD_ENT;
                end

                // entry reads issued
                S_RD_ENT:
                begin
                    state_reg <= S_GOT_ENT;
                end

                // transition and current q in hand
                S_GOT_ENT:
                begin
                    next_reg <= succ_rd_reg;
                    r_reg    <= rew_rd_reg;
                    q_reg    <= q_rd_reg;
                    newq_reg <= q_rd_reg;
                    if (cmd_reg == tqls_pkg::CMD_LEARN)
                    begin
                        scan_second_reg <= 1'b1;
                        state_reg       <= S_RD_MARK;
                    end
                    else
                    begin
                        state_reg <= S_RD_GOAL;
                    end
                end

                // gamma times successor max
                S_MUL1:
                begin
                    mul_a_reg <= {best_q_reg[31], best_q_reg};
                    mul_b_reg <= {1'b0, discount_reg};
                    state_reg <= S_MUL1W;
                end

                S_MUL1W:
                begin
                    state_reg <= S_ADD1;
                end

                // target = sat(reward + scaled max)
                S_ADD1:
                begin
                    target_reg <= add_sat;
                    state_reg  <= S_SUB1;
                end

                // alpha times error
                S_SUB1:
                begin
                    mul_a_reg <= {target_reg[31], target_reg} - {q_reg[31], q_reg};
                    mul_b_reg <= {1'b0, learn_rate_reg};
                    state_reg <= S_MUL2W;
                end

                S_MUL2W:
                begin
                    state_reg <= S_ADD2;
                end

                // new q, written back in the memory block
                S_ADD2:
                begin
                    newq_reg  <= add_sat;
                    state_reg <= S_RD_GOAL;
                end

                // goal read of the successor issued
                S_RD_GOAL:
                begin
                    state_reg <= S_OUT;
                end

                // result beat
                S_OUT:
                begin
                    done_reg <= 1'b1;
                    if (cmd_reg == tqls_pkg::CMD_LOAD || cmd_reg == tqls_pkg::CMD_MARK)
                    begin
                        chosen_out_reg  <= '0;
                        taken_out_reg   <= '0;
                        reached_out_reg <= '0;
                        reward_out_reg  <= '0;
                        newq_out_reg    <= '0;
                        goal_out_reg    <= 1'b0;
                    end
                    else
                    begin
                        chosen_out_reg  <= 3'(chosen_reg);
                        taken_out_reg   <= 3'(taken_reg);
                        reached_out_reg <= 12'(next_reg);
                        reward_out_reg  <= r_reg;
                        newq_out_reg    <= newq_reg;
                        goal_out_reg    <= goal_rd_reg;
                    end
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign chosen_action = chosen_out_reg;
    assign taken_action  = taken_out_reg;
    assign reached_state = reached_out_reg;
    assign step_reward   = reward_out_reg;
    assign updated_q     = newq_out_reg;
    assign at_goal       = goal_out_reg;

endmodule

FILE: tb/sv/tabular_q_learning_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabular_q_learning_step_unit_tb
// Self-checking bench for the tabular Q-learning step unit.
// ----------------------------------------------------------------------------
// Command beats go in at the falling edge and result beats are sampled at the
// rising edge. An in-bench mirror of the Q, reward, successor and mark tables
// predicts each result not given by the directed table, and each result beat
// is checked field by field against the oldest pending expected result; steps
// only touch a fixed set of fully loaded states whose successors stay inside
// that set, so no table entry is read before it is written. A short directed
// table comes first, then random traffic under several register settings with
// random command gaps. Registers are written over the APB port and read back.
// ----------------------------------------------------------------------------
module tabular_q_learning_step_unit_tb;

    import tqls_pkg::*;

    localparam int NA              = ACTION_COUNT_DEF;
    localparam int NS              = STATE_COUNT_DEF;
    localparam int POOL_SIZE       = 12;
    localparam int NUM_SETTINGS    = 5;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int DIR_ROWS        = 22;

    localparam logic [11:0] S_TOP    = 12'd4095;
    localparam logic [15:0] DRAW_MAX = 16'hFFFF;

    // one command beat
    typedef struct packed {
        logic [1:0]         op;
        logic [11:0]        st;
        logic [2:0]         act;
        logic signed [31:0] rew;
        logic [11:0]        tgt;
        logic               seven;
        logic [15:0]        ex_draw;
        logic [15:0]        ex_pick;
        logic [15:0]        sl_draw;
        logic [15:0]        sl_pick;
    } q_cmd_t;

    // one result beat
    typedef struct packed {
        logic [2:0]         chosen;
        logic [2:0]         taken;
        logic [11:0]        reached;
        logic signed [31:0] reward;
        logic signed [31:0] newq;
        logic               goal;
    } q_result_t;

    typedef struct packed {
        q_cmd_t    c;
        logic      typed;
        q_result_t want;
    } dir_row_t;

    localparam q_result_t NO_RESULT = '0;
    localparam q_result_t TOP_EVAL  = '{3'd0, 3'd0, S_TOP, 32'sh7FFFFFFF, 32'sd0, 1'b1};

    // directed rows: all but one goal mark work on the top state, which loops back to itself
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{'{CMD_LOAD, S_TOP, 3'd7, 32'sh7FFFFFFF, S_TOP, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_LOAD, S_TOP, 3'd0, 32'sh7FFFFFFF, S_TOP, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_LOAD, S_TOP, 3'd1, 32'sh80000000, S_TOP, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_LOAD, S_TOP, 3'd2, 32'sh00000000, S_TOP, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_LOAD, S_TOP, 3'd3, 32'sh00000001, S_TOP, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_LOAD, S_TOP, 3'd4, 32'shFFFFFFFF, S_TOP, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_LOAD, S_TOP, 3'd5, 32'sh00010000, S_TOP, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_LOAD, S_TOP, 3'd6, 32'shFFFF0000, S_TOP, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_MARK, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_MARK, 12'd0, 3'd0, 32'sh0, 12'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        // all Q equal, so the first action wins
        '{'{CMD_EVAL, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, DRAW_MAX, 16'd0, DRAW_MAX, 16'd0},
          1'b1, TOP_EVAL},
        '{'{CMD_EVAL, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, DRAW_MAX, 16'd0, 16'd0, DRAW_MAX},
          1'b0, NO_RESULT},
        // slip draw right at and just above the threshold
        '{'{CMD_EVAL, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, DRAW_MAX, 16'd0, 16'd6554, 16'd6},
          1'b0, NO_RESULT},
        '{'{CMD_EVAL, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, DRAW_MAX, 16'd0, 16'd6555, 16'd6},
          1'b0, NO_RESULT},
        '{'{CMD_LEARN, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, DRAW_MAX, 16'd0, DRAW_MAX, 16'd0},
          1'b0, NO_RESULT},
        '{'{CMD_LEARN, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, 16'd6554, 16'd3, DRAW_MAX, 16'd0},
          1'b0, NO_RESULT},
        '{'{CMD_LEARN, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, 16'd0, DRAW_MAX, DRAW_MAX, 16'd0},
          1'b0, NO_RESULT},
        '{'{CMD_LEARN, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, 16'd6555, 16'd3, DRAW_MAX, 16'd0},
          1'b0, NO_RESULT},
        // evaluate never explores
        '{'{CMD_EVAL, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, 16'd0, 16'd5, DRAW_MAX, 16'd0},
          1'b0, NO_RESULT},
        // drop the seventh action again
        '{'{CMD_LOAD, S_TOP, 3'd6, 32'sh00008000, S_TOP, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, NO_RESULT},
        '{'{CMD_EVAL, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, DRAW_MAX, 16'd0, 16'd0, DRAW_MAX},
          1'b0, NO_RESULT},
        '{'{CMD_LEARN, S_TOP, 3'd0, 32'sh0, 12'd0, 1'b0, 16'd0, DRAW_MAX, 16'd0, 16'd0},
          1'b0, NO_RESULT}
    };

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         cmd;
    logic [11:0]        state_index;
    logic [2:0]         action_index;
    logic signed [31:0] entry_reward;
    logic [11:0]        entry_target;
    logic               has_seven_actions;
    logic [15:0]        explore_draw;
    logic [15:0]        explore_action_draw;
    logic [15:0]        slip_draw;
    logic [15:0]        slip_action_draw;
    logic               done;
    logic [2:0]         chosen_action;
    logic [2:0]         taken_action;
    logic [11:0]        reached_state;
    logic signed [31:0] step_reward;
    logic signed [31:0] updated_q;
    logic               at_goal;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // mirror of the tables and registers
    logic signed [31:0] q_mirror      [NS*NA];
    logic signed [31:0] reward_mirror [NS*NA];
    logic [11:0]        succ_mirror   [NS*NA];
    bit                 goal_mark     [NS];
    bit                 seven_mark    [NS];
    logic [15:0]        alpha_cfg   = LEARN_RATE_RST;
    logic [15:0]        gamma_cfg   = DISCOUNT_RST;
    logic [15:0]        explore_cfg = EXPLORE_RST;
    logic [15:0]        slip_cfg    = SLIP_RST;

    // states that steps may touch
    logic [11:0] pool [POOL_SIZE];
    bit          in_pool [NS];

    q_result_t awaited_results [$];
    int        op_count [4];
    int        results_checked = 0;
    int        mismatches = 0;
    int        burst_left = 0;

    tabular_q_learning_step_unit DUT (.*);

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 60)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int unsigned usable_actions(input logic [11:0] s);
        return seven_mark[s] ? NA : NA - 1;
    endfunction

    // first maximum wins
    function automatic int unsigned best_action(input logic [11:0] s);
        int unsigned n;
        int unsigned best;
        int          base;
        n = usable_actions(s);
        best = 0;
        base = int'(s) * NA;
        for (int unsigned a = 1; a < n; a++)
            if (q_mirror[base + a] > q_mirror[base + best])
                best = a;
        return best;
    endfunction

    // round(x * f / 2^16), ties up
    function automatic longint frac_mul(input longint x, input logic [15:0] f);
        longint fl;
        fl = f;
        return (x * fl + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic q_result_t compute_q_step(input q_cmd_t c);
        q_result_t   o;
        int unsigned n;
        int unsigned chosen;
        int unsigned taken;
        int          base;
        logic [11:0] nxt;
        longint      q;
        longint      r;
        longint      nq;
        longint      nmax;
        longint      aim;
        o = '0;
        base = int'(c.st) * NA;
        case (c.op)
            CMD_LOAD:
            begin
                if (c.act < NA)
                begin
                    q_mirror[base + c.act]      = '0;
                    reward_mirror[base + c.act] = c.rew;
                    succ_mirror[base + c.act]   = c.tgt;
                    seven_mark[c.st]            = c.seven;
                end
            end
            CMD_MARK:
                goal_mark[c.st] = 1'b1;
            default:
            begin
                n = usable_actions(c.st);
                if (c.op == CMD_LEARN && c.ex_draw <= explore_cfg)
                    chosen = c.ex_pick % n;
                else
                    chosen = best_action(c.st);
                taken = (c.sl_draw <= slip_cfg) ? c.sl_pick % n : chosen;
                nxt = succ_mirror[base + taken];
                r   = reward_mirror[base + taken];
                q   = q_mirror[base + chosen];
                if (c.op == CMD_LEARN)
                begin
                    nmax = q_mirror[int'(nxt) * NA + best_action(nxt)];
                    aim  = clamp_q16(r + frac_mul(nmax, gamma_cfg));
                    nq   = clamp_q16(q + frac_mul(aim - q, alpha_cfg));
                    q_mirror[base + chosen] = nq[31:0];
                end
                else
                    nq = q;
                o.chosen  = chosen[2:0];
                o.taken   = taken[2:0];
                o.reached = nxt;
                o.reward  = r[31:0];
                o.newq    = nq[31:0];
                o.goal    = goal_mark[nxt];
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // random picks
    // ------------------------------------------------------------------
    function automatic logic [11:0] pool_state();
        return pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [15:0] pick_draw(input logic [15:0] thr);
        case ($urandom_range(0, 7))
            0: return thr;
            1: return thr + 16'd1;
            2: return 16'd0;
            3: return DRAW_MAX;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_reward();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3, 4, 5: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return 32'($urandom);
        endcase
    endfunction

    // mostly short gaps, a few long ones, and bursts with none
    function automatic int pick_gap();
        int unsigned r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 82)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // steps and most loads stay on the pool; some loads and marks go anywhere
    function automatic q_cmd_t random_q_cmd();
        q_cmd_t      c;
        int unsigned r;
        c.ex_draw = pick_draw(explore_cfg);
        c.ex_pick = 16'($urandom);
        c.sl_draw = pick_draw(slip_cfg);
        c.sl_pick = 16'($urandom);
        c.rew     = pick_reward();
        c.seven   = 1'($urandom);
        c.act     = 3'($urandom);
        c.tgt     = 12'($urandom);
        c.st      = pool_state();
        r = $urandom_range(0, 99);
        if (r < 45)
            c.op = CMD_LEARN;
        else if (r < 65)
            c.op = CMD_EVAL;
        else if (r < 88)
        begin
            c.op = CMD_LOAD;
            if (r >= 82)
                c.st = 12'($urandom);
            if (in_pool[c.st])
                c.tgt = pool_state();
        end
        else
        begin
            c.op = CMD_MARK;
            if (r >= 95)
                c.st = 12'($urandom);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------
    task automatic issue_cmd(input q_cmd_t c, input logic typed, input q_result_t want);
        q_result_t pred;
        @(negedge clk);
        start               = 1'b1;
        cmd                 = c.op;
        state_index         = c.st;
        action_index        = c.act;
        entry_reward        = c.rew;
        entry_target        = c.tgt;
        has_seven_actions   = c.seven;
        explore_draw        = c.ex_draw;
        explore_action_draw = c.ex_pick;
        slip_draw           = c.sl_draw;
        slip_action_draw    = c.sl_pick;
        do
            @(posedge clk);
        while (busy);
        pred = compute_q_step(c);
        awaited_results.push_back(typed ? want : pred);
        op_count[c.op]++;
    endtask

    // start low, fields scrambled
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start               = 1'b0;
            cmd                 = 2'($urandom);
            state_index         = 12'($urandom);
            action_index        = 3'($urandom);
            entry_reward        = 32'($urandom);
            entry_target        = 12'($urandom);
            has_seven_actions   = 1'($urandom);
            explore_draw        = 16'($urandom);
            explore_action_draw = 16'($urandom);
            slip_draw           = 16'($urandom);
            slip_action_draw    = 16'($urandom);
        end
    endtask

    task automatic drain_results(input int settle);
        idle_cycles(1);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'($urandom), val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [15:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== want)
            flag_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata[15:0], want));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] a, input logic [15:0] g,
                                  input logic [15:0] e, input logic [15:0] s,
                                  input bit do_write);
        if (do_write)
        begin
            write_reg(REG_LEARN_RATE, a);
            write_reg(REG_DISCOUNT, g);
            write_reg(REG_EXPLORE, e);
            write_reg(REG_SLIP, s);
            alpha_cfg   = a;
            gamma_cfg   = g;
            explore_cfg = e;
            slip_cfg    = s;
        end
        read_reg(REG_LEARN_RATE, alpha_cfg);
        read_reg(REG_DISCOUNT, gamma_cfg);
        read_reg(REG_EXPLORE, explore_cfg);
        read_reg(REG_SLIP, slip_cfg);
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        q_result_t w;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
                flag_mismatch("result beat with no command pending");
            else
            begin
                w = awaited_results.pop_front();
                results_checked++;
                if (chosen_action !== w.chosen)
                    flag_mismatch($sformatf("beat %0d chosen_action %0d, want %0d",
                                            results_checked, chosen_action, w.chosen));
                if (taken_action !== w.taken)
                    flag_mismatch($sformatf("beat %0d taken_action %0d, want %0d",
                                            results_checked, taken_action, w.taken));
                if (reached_state !== w.reached)
                    flag_mismatch($sformatf("beat %0d reached_state %0d, want %0d",
                                            results_checked, reached_state, w.reached));
                if (step_reward !== w.reward)
                    flag_mismatch($sformatf("beat %0d step_reward %h, want %h",
                                            results_checked, step_reward, w.reward));
                if (updated_q !== w.newq)
                    flag_mismatch($sformatf("beat %0d updated_q %h, want %h",
                                            results_checked, updated_q, w.newq));
                if (at_goal !== w.goal)
                    flag_mismatch($sformatf("beat %0d at_goal %0d, want %0d",
                                            results_checked, at_goal, w.goal));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        q_cmd_t      c;
        logic [11:0] cand;
        rst_n               = 1'b0;
        start               = 1'b0;
        cmd                 = CMD_LOAD;
        state_index         = '0;
        action_index        = '0;
        entry_reward        = '0;
        entry_target        = '0;
        has_seven_actions   = 1'b0;
        explore_draw        = '0;
        explore_action_draw = '0;
        slip_draw           = '0;
        slip_action_draw    = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        foreach (op_count[i])
            op_count[i] = 0;

        // pool always holds both ends of the state range
        pool[0] = 12'd0;
        pool[1] = S_TOP;
        in_pool[pool[0]] = 1'b1;
        in_pool[pool[1]] = 1'b1;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            do
                cand = 12'($urandom);
            while (in_pool[cand]);
            pool[i] = cand;
            in_pool[cand] = 1'b1;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values, read during the goal clearing pass
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            issue_cmd(DIRECTED[i].c, DIRECTED[i].typed, DIRECTED[i].want);
            idle_cycles(pick_gap());
        end

        // fill every entry of the pool states
        foreach (pool[i])
            for (int a = 0; a < NA; a++)
            begin
                c     = random_q_cmd();
                c.op  = CMD_LOAD;
                c.st  = pool[i];
                c.act = 3'(a);
                c.tgt = pool_state();
                issue_cmd(c, 1'b0, NO_RESULT);
                idle_cycles(pick_gap());
            end

        // random traffic under each register setting
        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            if (ph > 0)
            begin
                drain_results(2);
                case (ph)
                    1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                    2: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
                    3: apply_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
                    default: apply_settings(16'($urandom), 16'($urandom),
                                            16'($urandom), 16'($urandom), 1'b1);
                endcase
            end
            repeat (ITEMS_PER_PHASE)
            begin
                issue_cmd(random_q_cmd(), 1'b0, NO_RESULT);
                idle_cycles(pick_gap());
            end
        end

        drain_results(100);
        $display("covered %0d loads, %0d goal marks, %0d learn steps, %0d evaluate steps",
                 op_count[CMD_LOAD], op_count[CMD_MARK], op_count[CMD_LEARN],
                 op_count[CMD_EVAL]);
        $display("over %0d register settings; %0d result beats checked, %0d mismatches",
                 NUM_SETTINGS, results_checked, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #8_000_000;
        $display("timeout with %0d results still pending", awaited_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/tqls_pkg.sv
src/tabular_q_learning_step_unit.sv
tb/sv/tabular_q_learning_step_unit_tb.sv
